>>> rtl/csov_pkg.sv
// shared constants, types and stripe table for the checkerboard stripe overlay
package csov_pkg;

    localparam int COORD_BITS     = 12;
    localparam int CELL_BITS      = COORD_BITS - 2;
    localparam int INDEX_BITS     = 4;
    localparam int STRIPE_COUNT   = 9;
    localparam int PIXEL_BITS     = 32;
    localparam int RGB_BITS       = 24;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int QUEUE_DEPTH    = 2;
    localparam int SETTLE_CYCLES  = 2;
    localparam int SETTLE_BITS    = $clog2(SETTLE_CYCLES + 1);

    // divide by nine through a scaled reciprocal, exact for any COORD_BITS-wide value
    localparam int DIV_SHIFT  = COORD_BITS + 3;
    localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + STRIPE_COUNT - 1) / STRIPE_COUNT;
    localparam int PROD_BITS  = 2 * COORD_BITS + 1;
    localparam int QUOT_BITS  = PROD_BITS - DIV_SHIFT;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CELL_BITS-1:0]  cell_t;
    typedef logic [INDEX_BITS-1:0] stripe_idx_t;

    localparam stripe_idx_t STRIPE_LAST = stripe_idx_t'(STRIPE_COUNT - 1);
    localparam coord_t      COORD_MAX   = '1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_X    = 3'd0,
        CFG_START_Y    = 3'd1,
        CFG_END_X      = 3'd2,
        CFG_END_Y      = 3'd3,
        CFG_BACKGROUND = 3'd4
    } cfg_reg_t;

    // one classified word waiting for the back end
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  frame_start;
        logic                  is_bg;
    } csov_entry_t;

    // geometry and status from the configuration unit
    typedef struct packed {
        coord_t              span;
        coord_t              stripe_height;
        logic [RGB_BITS-1:0] background;
        logic                busy;
    } csov_geom_t;

    // stripe colour table, saturating at the last entry
    function automatic logic [PIXEL_BITS-1:0] stripe_colour(stripe_idx_t idx);
        logic [PIXEL_BITS-1:0] colour;
        case (idx)
            4'd0:    colour = 32'h000F_FC00;
            4'd1:    colour = 32'h000F_FC00;
            4'd2:    colour = 32'h000F_FC00;
            4'd3:    colour = 32'h3FFF_FC00;
            4'd4:    colour = 32'h3FEA_C000;
            4'd5:    colour = 32'h3F00_0000;
            4'd6:    colour = 32'h2F96_03FF;
            4'd7:    colour = 32'h0000_03FF;
            default: colour = 32'h0000_03FF;
        endcase
        return colour;
    endfunction

endpackage

>>> rtl/csov_in_if.sv
// input channel: existing pixel word and frame start flag
interface csov_in_if;
    import csov_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;
    logic                  frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

>>> rtl/csov_out_if.sv
// output channel: pixel word to write back and row end flag
interface csov_out_if;
    import csov_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  row_end;

    modport source (output valid, output pixel_out, output row_end, input ready);
    modport sink   (input valid, input pixel_out, input row_end, output ready);
endinterface

>>> rtl/csov_geom.sv
// configuration registers, row span and stripe height divider
module csov_geom (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [csov_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [csov_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output csov_pkg::csov_geom_t                   geom
);
    import csov_pkg::*;

    coord_t                start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [RGB_BITS-1:0]   background_reg;
    coord_t                diff_reg, diff_next;
    logic [QUOT_BITS-1:0]  quot_reg;
    coord_t                span_reg;
    logic [SETTLE_BITS-1:0] settle_reg, settle_next;
    logic [PROD_BITS-1:0]  prod;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            background_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_X:    start_x_reg    <= cfg_data[COORD_BITS-1:0];
                CFG_START_Y:    start_y_reg    <= cfg_data[COORD_BITS-1:0];
                CFG_END_X:      end_x_reg      <= cfg_data[COORD_BITS-1:0];
                CFG_END_Y:      end_y_reg      <= cfg_data[COORD_BITS-1:0];
                CFG_BACKGROUND: background_reg <= cfg_data[RGB_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // vertical extent, zero when the range is inverted
    always_comb
    begin
        if (end_y_reg >= start_y_reg)
            diff_next = end_y_reg - start_y_reg;
        else
            diff_next = '0;
    end

    // divide by nine with the reciprocal multiply
    assign prod = PROD_BITS'(diff_reg) * PROD_BITS'(DIV_RECIP);

    // settle counter holds off input while the quotient updates
    always_comb
    begin
        if (cfg_we)
            settle_next = SETTLE_BITS'(SETTLE_CYCLES);
        else if (settle_reg != '0)
            settle_next = settle_reg - 1'b1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg   <= '0;
            quot_reg   <= '0;
            span_reg   <= '0;
            settle_reg <= '0;
        end
        else
        begin
            diff_reg   <= diff_next;
            quot_reg   <= prod[PROD_BITS-1:DIV_SHIFT];
            span_reg   <= end_x_reg - start_x_reg;
            settle_reg <= settle_next;
        end
    end

    assign geom.span          = span_reg;
    assign geom.stripe_height = COORD_BITS'(quot_reg);
    assign geom.background    = background_reg;
    assign geom.busy          = cfg_we || (settle_reg != '0);

`ifndef ASSERT_OFF
    // a write keeps the input held off on the following cycle
    a_write_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> geom.busy)
        else $error("configuration write did not hold off input");
`endif

endmodule

>>> rtl/csov_front.sv
// front end: accepts input words and classifies them against the background
module csov_front (
    csov_in_if.sink                   in_ch,
    input  csov_pkg::csov_geom_t      geom,
    input  logic                      queue_full,
    output logic                      push,
    output csov_pkg::csov_entry_t     entry
);
    import csov_pkg::*;

    // take a word when the queue has room and the geometry is settled
    assign in_ch.ready = !queue_full && !geom.busy;
    assign push        = in_ch.valid && in_ch.ready;

    // background test on the colour bits
    assign entry.pixel       = in_ch.pixel_in;
    assign entry.frame_start = in_ch.frame_start;
    assign entry.is_bg       = (in_ch.pixel_in[PIXEL_BITS-1:PIXEL_BITS-RGB_BITS]
                                == geom.background);

endmodule

>>> rtl/csov_queue.sv
// short queue between the front and back ends
module csov_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  csov_pkg::csov_entry_t     push_entry,
    input  logic                      pop,
    output csov_pkg::csov_entry_t     pop_entry,
    output logic                      empty,
    output logic                      full
);
    import csov_pkg::*;

    localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    csov_entry_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_BITS-1:0]   count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
    assign pop_entry = slot_reg[rd_ptr_reg];

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers wrap over the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/csov_back.sv
// back end: checkerboard and stripe counters, colour choice and output register
module csov_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  csov_pkg::csov_geom_t      geom,
    input  logic                      queue_empty,
    input  csov_pkg::csov_entry_t     entry,
    output logic                      pop,
    csov_out_if.source                out_ch
);
    import csov_pkg::*;

    coord_t                 column_pos_reg, column_pos_next;
    coord_t                 row_cell_count_reg, row_cell_count_next;
    logic                   row_starts_black_reg, row_starts_black_next;
    coord_t                 stripe_row_count_reg, stripe_row_count_next;
    stripe_idx_t            stripe_index_reg, stripe_index_next;
    coord_t                 col_cell_count_reg, col_cell_count_next;
    logic                   cell_is_black_reg, cell_is_black_next;
    coord_t                 stripe_height_reg, stripe_height_next;
    cell_t                  cell_size_reg, cell_size_next;
    logic                   out_valid_reg;
    logic [PIXEL_BITS-1:0]  pixel_out_reg, pixel_out_next;
    logic                   row_end_reg, row_end_next;

    // advance when the output register is free or being emptied
    assign pop = !queue_empty && (!out_valid_reg || out_ch.ready);

    // per word counter update
    always_comb
    begin
        coord_t      cp, rcc, src, ccc;
        logic        rsb, cib, last;
        stripe_idx_t si;
        coord_t      sh, cs_wide;
        cell_t       cs;

        cp  = column_pos_reg;
        rcc = row_cell_count_reg;
        rsb = row_starts_black_reg;
        src = stripe_row_count_reg;
        si  = stripe_index_reg;
        ccc = col_cell_count_reg;
        cib = cell_is_black_reg;
        sh  = stripe_height_reg;
        cs  = cell_size_reg;

        // frame start clears the counters and latches the geometry
        if (entry.frame_start)
        begin
            cp  = '0;
            rcc = '0;
            rsb = 1'b0;
            src = '0;
            si  = '0;
            ccc = '0;
            cib = 1'b0;
            sh  = geom.stripe_height;
            cs  = geom.stripe_height[COORD_BITS-1:2];
        end
        cs_wide = COORD_BITS'(cs);

        // row start: cell row toggle and stripe advance
        if (cp == '0)
        begin
            if (cs != '0)
            begin
                rcc = rcc + 1'b1;
                if (rcc == cs_wide)
                begin
                    rcc = '0;
                    rsb = !rsb;
                    if (src >= sh)
                    begin
                        src = '0;
                        if (si < STRIPE_LAST)
                            si = si + 1'b1;
                    end
                end
            end
            if (src != COORD_MAX)
                src = src + 1'b1;
            cib = rsb;
            ccc = '0;
        end

        // column toggle
        if (cs != '0)
        begin
            ccc = ccc + 1'b1;
            if (ccc == cs_wide)
            begin
                ccc = '0;
                cib = !cib;
            end
        end

        // colour choice
        if (entry.is_bg)
            pixel_out_next = entry.pixel;
        else if (cib)
            pixel_out_next = '0;
        else
            pixel_out_next = stripe_colour(si);

        last         = (cp == geom.span);
        row_end_next = last;

        column_pos_next       = last ? '0 : cp + 1'b1;
        row_cell_count_next   = rcc;
        row_starts_black_next = rsb;
        stripe_row_count_next = src;
        stripe_index_next     = si;
        col_cell_count_next   = ccc;
        cell_is_black_next    = cib;
        stripe_height_next    = sh;
        cell_size_next        = cs;
    end

    // counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_pos_reg       <= '0;
            row_cell_count_reg   <= '0;
            row_starts_black_reg <= 1'b0;
            stripe_row_count_reg <= '0;
            stripe_index_reg     <= '0;
            col_cell_count_reg   <= '0;
            cell_is_black_reg    <= 1'b0;
            stripe_height_reg    <= '0;
            cell_size_reg        <= '0;
        end
        else if (pop)
        begin
            column_pos_reg       <= column_pos_next;
            row_cell_count_reg   <= row_cell_count_next;
            row_starts_black_reg <= row_starts_black_next;
            stripe_row_count_reg <= stripe_row_count_next;
            stripe_index_reg     <= stripe_index_next;
            col_cell_count_reg   <= col_cell_count_next;
            cell_is_black_reg    <= cell_is_black_next;
            stripe_height_reg    <= stripe_height_next;
            cell_size_reg        <= cell_size_next;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pixel_out_reg <= pixel_out_next;
            row_end_reg   <= row_end_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel_out = pixel_out_reg;
    assign out_ch.row_end   = row_end_reg;

`ifndef ASSERT_OFF
    // stripe index never runs past the table
    a_stripe_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        stripe_index_reg <= STRIPE_LAST)
        else $error("stripe index past last table entry");

    // column cell counter stays below the cell size, and at zero with no cells
    a_cell_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_size_reg == '0) ? (col_cell_count_reg == '0)
                              : (col_cell_count_reg < COORD_BITS'(cell_size_reg)))
        else $error("column cell counter out of range");

    // a word taken from the queue shows up at the output
    a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped word did not reach the output register");
`endif

endmodule

>>> rtl/checkerboard_stripe_overlay_core.sv
// top level of the checkerboard stripe overlay
//
// in_ch carries existing pixel words of a rectangle in raster order, with
// frame_start set on the first word of the rectangle. out_ch returns one word
// for each input word, in order: the pixel unchanged when its colour equals
// the background, otherwise black or the current stripe colour following a
// checkerboard. row_end marks the last word of each row.
// The cfg port writes start_x, start_y, end_x, end_y and background_rgb by
// index while no words are in flight. A write holds in_ch.ready low while
// the stripe height (vertical extent divided by nine, through a registered
// reciprocal multiply) settles.
// Throughput is one word per cycle while out_ch.ready stays high and no
// configuration write holds off input; the back end counter update is a
// combinational recurrence. An accepted word waits in the queue until the
// output register is free, and is registered at the output as it is popped.
// When the receiver stalls, the output register holds its word and the
// two-entry queue takes two more words before in_ch.ready falls.
// Reset clears the configuration, counter and control registers to zero; the
// queue slots and output payload are not reset. The block takes words right after reset.
module checkerboard_stripe_overlay_core (
    input  logic                                clk,
    input  logic                                rst_n,
    csov_in_if.sink                             in_ch,
    csov_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [csov_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [csov_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import csov_pkg::*;

    csov_geom_t  geom;
    csov_entry_t push_entry;
    csov_entry_t pop_entry;
    logic        push;
    logic        pop;
    logic        queue_empty;
    logic        queue_full;

    // configuration and geometry
    csov_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // accept and classify
    csov_front u_front (
        .in_ch      (in_ch),
        .geom       (geom),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    // decoupling queue
    csov_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    // counters and colour choice
    csov_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .queue_empty (queue_empty),
        .entry       (pop_entry),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

>>> tb/tb_checkerboard_stripe_overlay_core.sv
// self-checking testbench for the checkerboard stripe overlay core
`timescale 1ns / 100ps

module tb_checkerboard_stripe_overlay_core;
    import csov_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int WORD_TARGET  = 800;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    // predicts each output word and checks the words that come back
    class overlay_scoreboard;
        coord_t                start_x;
        coord_t                start_y;
        coord_t                end_x;
        coord_t                end_y;
        logic [RGB_BITS-1:0]   background;
        coord_t                column_pos;
        coord_t                row_cell_count;
        coord_t                stripe_row_count;
        coord_t                col_cell_count;
        coord_t                stripe_height;
        cell_t                 cell_size;
        stripe_idx_t           stripe_index;
        bit                    row_starts_black;
        bit                    cell_is_black;
        logic [PIXEL_BITS-1:0] stripe_rgb [STRIPE_COUNT];
        logic [PIXEL_BITS-1:0] pending_pixel [$];
        bit                    pending_row_end [$];
        int                    words_in;
        int                    words_out;
        int                    frame_starts;
        int                    failures;
        int                    deepest_stripe;

        function new();
            stripe_rgb = '{32'h000F_FC00, 32'h000F_FC00, 32'h000F_FC00, 32'h3FFF_FC00,
                           32'h3FEA_C000, 32'h3F00_0000, 32'h2F96_03FF, 32'h0000_03FF,
                           32'h0000_03FF};
            start_x = '0; start_y = '0; end_x = '0; end_y = '0; background = '0;
            column_pos = '0; row_cell_count = '0; stripe_row_count = '0;
            col_cell_count = '0; stripe_height = '0; cell_size = '0;
            stripe_index = '0; row_starts_black = 0; cell_is_black = 0;
            words_in = 0; words_out = 0; frame_starts = 0; failures = 0;
            deepest_stripe = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_START_X:    start_x = data[COORD_BITS-1:0];
                CFG_START_Y:    start_y = data[COORD_BITS-1:0];
                CFG_END_X:      end_x = data[COORD_BITS-1:0];
                CFG_END_Y:      end_y = data[COORD_BITS-1:0];
                CFG_BACKGROUND: background = data[RGB_BITS-1:0];
                default:        ;
            endcase
        endfunction

        // advance the counters for one accepted word and queue its result
        function void note_word(logic [PIXEL_BITS-1:0] pixel, bit fs);
            coord_t                span;
            logic [PIXEL_BITS-1:0] colour;
            bit                    last;
            span = end_x - start_x;
            words_in++;

            // frame start clears the counters and latches the geometry
            if (fs)
            begin
                frame_starts++;
                column_pos = '0; row_cell_count = '0; row_starts_black = 0;
                stripe_row_count = '0; stripe_index = '0; col_cell_count = '0;
                cell_is_black = 0;
                stripe_height = (end_y >= start_y) ? coord_t'((end_y - start_y) / STRIPE_COUNT)
                                                   : '0;
                cell_size = cell_t'(stripe_height / 4);
            end

            // row start: cell row toggle and stripe advance
            if (column_pos == '0)
            begin
                if (cell_size != '0)
                begin
                    row_cell_count = row_cell_count + 1'b1;
                    if (row_cell_count == coord_t'(cell_size))
                    begin
                        row_cell_count = '0;
                        row_starts_black = !row_starts_black;
                        if (stripe_row_count >= stripe_height)
                        begin
                            stripe_row_count = '0;
                            if (stripe_index < STRIPE_LAST)
                                stripe_index = stripe_index + 1'b1;
                        end
                    end
                end
                if (stripe_row_count != COORD_MAX)
                    stripe_row_count = stripe_row_count + 1'b1;
                cell_is_black = row_starts_black;
                col_cell_count = '0;
            end

            // column toggle inside the row
            if (cell_size != '0)
            begin
                col_cell_count = col_cell_count + 1'b1;
                if (col_cell_count == coord_t'(cell_size))
                begin
                    col_cell_count = '0;
                    cell_is_black = !cell_is_black;
                end
            end

            if (pixel[PIXEL_BITS-1:8] != background)
                colour = cell_is_black ? '0
                       : stripe_rgb[(stripe_index > STRIPE_LAST) ? STRIPE_LAST : stripe_index];
            else
                colour = pixel;
            if (int'(stripe_index) > deepest_stripe)
                deepest_stripe = int'(stripe_index);

            last = (column_pos == span);
            column_pos = last ? '0 : column_pos + 1'b1;
            pending_pixel.push_back(colour);
            pending_row_end.push_back(last);
        endfunction

        function void check_word(logic [PIXEL_BITS-1:0] pixel, logic row_end);
            logic [PIXEL_BITS-1:0] want_pixel;
            bit                    want_end;
            words_out++;
            if (pending_pixel.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("tb: unexpected output word %h row_end %b", pixel, row_end);
                return;
            end
            want_pixel = pending_pixel.pop_front();
            want_end = pending_row_end.pop_front();
            if (pixel !== want_pixel || row_end !== want_end)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("tb: word %0d pixel_out %h expected %h, row_end %b expected %b",
                             words_out - 1, pixel, want_pixel, row_end, want_end);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    bit                        calm;
    int                        hold_requests = 0;
    int                        holds_done = 0;
    int                        long_left = 0;
    int                        stall_left = 0;
    int                        cycles = 0;
    int                        settings_used = 0;
    overlay_scoreboard         board = new();

    csov_in_if  in_ch ();
    csov_out_if out_ch ();

    checkerboard_stripe_overlay_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // note accepted input words, then check accepted output words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                board.note_word(in_ch.pixel_in, in_ch.frame_start);
            if (out_ch.valid && out_ch.ready)
                board.check_word(out_ch.pixel_out, out_ch.row_end);
        end
    end

    // receiver: random stalls plus the requested long hold-off
    always @(negedge clk)
    begin
        if (holds_done < hold_requests)
        begin
            holds_done = holds_done + 1;
            long_left = LONG_HOLD;
        end
        if (long_left > 0)
        begin
            long_left = long_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 15)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // half background matches and near misses, the rest all ones, all zeros or arbitrary
    function automatic logic [PIXEL_BITS-1:0] pick_pixel();
        logic [RGB_BITS-1:0] near;
        near = board.background ^ (24'h1 << $urandom_range(0, RGB_BITS - 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {board.background, 8'($urandom)};
            4:          return {near, 8'($urandom)};
            5:          return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default:    return $urandom;
        endcase
    endfunction

    function automatic coord_t corner_coord();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return COORD_MAX;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_word(logic [PIXEL_BITS-1:0] pixel, bit fs);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.pixel_in <= pixel;
        in_ch.frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // stop sending and let every expected word come back
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (board.pending_pixel.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // coordinate writes carry junk in the unused upper bits
    task automatic apply_setting(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                 logic [RGB_BITS-1:0] bg);
        wait_idle();
        write_reg(CFG_START_X, {12'($urandom), sx});
        write_reg(CFG_START_Y, {12'($urandom), sy});
        write_reg(CFG_END_X, {12'($urandom), ex});
        write_reg(CFG_END_Y, {12'($urandom), ey});
        write_reg(CFG_BACKGROUND, bg);
        settings_used++;
    endtask

    task automatic random_setting(output int words);
        int                  kind;
        coord_t              sx;
        coord_t              sy;
        coord_t              ex;
        coord_t              ey;
        logic [RGB_BITS-1:0] bg;
        kind = $urandom_range(0, 19);
        sx = coord_t'($urandom);
        sy = coord_t'($urandom_range(0, 4000));
        words = $urandom_range(10, 80);
        if (kind < 10)
        begin
            // narrow rows and small cells, deep enough to run off the stripe table
            ex = sx + coord_t'($urandom_range(0, 2));
            ey = sy + coord_t'($urandom_range(36, 90));
            words = $urandom_range(60, 160);
        end
        else if (kind < 14)
        begin
            // height too small for a nonzero cell size
            ex = sx + coord_t'($urandom_range(0, 40));
            ey = sy + coord_t'($urandom_range(0, 35));
        end
        else if (kind < 17)
        begin
            sy = coord_t'($urandom);
            ex = coord_t'($urandom);
            ey = coord_t'($urandom);
        end
        else
        begin
            sx = corner_coord();
            sy = corner_coord();
            ex = corner_coord();
            ey = corner_coord();
        end
        case ($urandom_range(0, 9))
            0:       bg = '0;
            1:       bg = '1;
            default: bg = RGB_BITS'($urandom);
        endcase
        apply_setting(sx, sy, ex, ey, bg);
    endtask

    task automatic run_frame(int words, bit with_start);
        int  i;
        bit  fs;
        for (i = 0; i < words; i++)
        begin
            fs = (i == 0 && with_start) || ($urandom_range(0, 149) == 0);
            send_word(pick_pixel(), fs);
        end
    endtask

    // main sequence
    initial
    begin
        int words;
        int phase;
        in_ch.valid = 1'b0;
        in_ch.pixel_in = '0;
        in_ch.frame_start = 1'b0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // words before any frame start, registers still at reset
        send_word(32'h0000_00AB, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h1234_5678, 1'b0);

        // widest rectangle, white background, one word before the frame start
        apply_setting('0, '0, COORD_MAX, COORD_MAX, '1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FF00, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FEFF, 1'b0);

        // inverted ranges on both axes, then a frame start mid-row
        apply_setting(12'd4000, 12'd100, 12'd3, 12'd50, 24'h5A5A5A);
        send_word(32'h5A5A_5A00, 1'b1);
        send_word(32'hA5A5_A5FF, 1'b0);
        send_word(32'h5A5A_5A7F, 1'b0);
        send_word(32'h0000_0000, 1'b1);

        // all-zero geometry: one-word rows, zero cell size
        apply_setting('0, '0, '0, '0, '0);
        send_word(32'h0000_00FF, 1'b1);
        send_word(32'h0000_0100, 1'b0);

        // cell size of one on two-word rows
        apply_setting(12'd7, '0, 12'd8, 12'd36, 24'h123456);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h1234_5601, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);

        // random settings and frames
        phase = 0;
        while (board.words_in < WORD_TARGET)
        begin
            random_setting(words);
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 1)
            begin
                hold_requests = hold_requests + 1;
                if (words < 40)
                    words = 40;
            end
            run_frame(words, $urandom_range(0, 9) != 0);
            phase++;
        end

        wait_idle();
        if (board.pending_pixel.size() != 0)
            board.failures++;
        $display("tb: %0d words checked over %0d register settings, %0d frame starts",
                 board.words_out, settings_used, board.frame_starts);
        $display("tb: deepest stripe entry %0d, long output hold-offs %0d",
                 board.deepest_stripe, holds_done);
        if (board.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/csov_pkg.sv
rtl/csov_in_if.sv
rtl/csov_out_if.sv
rtl/csov_geom.sv
rtl/csov_front.sv
rtl/csov_queue.sv
rtl/csov_back.sv
rtl/checkerboard_stripe_overlay_core.sv
tb/tb_checkerboard_stripe_overlay_core.sv
